[hw/rtl/hsd_pkg.sv]
// hsd_pkg: constants, status codes and coverage masks for the hamming secded decoder
// no dependencies; imported by hamming_secded_decoder
`default_nettype none

package hsd_pkg;

  // field widths
  localparam int CODEWORD_W = 64;
  localparam int DATA_W     = 57;
  localparam int SYN_W      = 6;
  localparam int CFG_W      = 3;
  localparam int CFG_IDX_W  = 2;

  // default upper bound, lower bound and reset value for the check bit count
  localparam int MAX_CHECK_BITS_DEF = 6;
  localparam logic [2:0] MIN_CHECK_BITS = 3'd2;
  localparam logic [2:0] RESET_CHECK_BITS = 3'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_BITS    = 2'd0,
    REG_ODD_PARITY    = 2'd1,
    REG_DOUBLE_DETECT = 2'd2
  } cfg_reg_t;

  // decode status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CORRECTED = 2'd1,
    STATUS_DOUBLE    = 2'd2
  } status_t;

  // codeword bit i (position i+1) is covered by check bit p when bit p of i+1 is set
  function automatic logic [CODEWORD_W-1:0] syn_mask(input int p);
    logic [CODEWORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < CODEWORD_W; i++) begin
      m[i] = (((i + 1) >> p) & 1) != 0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hamming_secded_decoder.sv]
// hamming_secded_decoder: single pass hamming sec / secded decoder with config port
// depends on hsd_pkg
`default_nettype none
// Accept (start high, busy low) loads in_cw; the result register then raises done.
// Throughput: one codeword per cycle while busy is low; an input register feeds one
// combinational pass (syndrome, correction, packing) into the result register.
// done is high for exactly one cycle per transaction; the receiver cannot stall.
// Reset (rst, synchronous): busy is high during reset and the cycle after it, no
// transaction is in flight, and the registers return to check_bits 3, even parity, sec.

module hamming_secded_decoder
  import hsd_pkg::*;
#(
  parameter int MAX_CHECK_BITS = MAX_CHECK_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration port
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  // command side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CODEWORD_W-1:0] codeword,
  // result side
  output logic                       done,
  output logic [DATA_W-1:0]          data_word,
  output logic [1:0]                 status,
  output logic [SYN_W-1:0]           syndrome,
  output logic                       overall_mismatch
);

  localparam logic [2:0] MaxR = 3'(MAX_CHECK_BITS);

  logic [2:0]            check_bits;
  logic                  odd_parity;
  logic                  double_detect;
  logic                  rst_q;
  logic                  in_valid;
  logic [CODEWORD_W-1:0] in_cw;

  logic [2:0]            r_eff;
  logic [SYN_W-1:0]      n;
  logic [CODEWORD_W-1:0] len_mask;
  logic [CODEWORD_W-1:0] cw_m;
  logic [SYN_W-1:0]      syn;
  logic                  overall;
  logic                  mismatch_next;
  status_t               status_next;
  logic [SYN_W-1:0]      flipped;
  logic [CODEWORD_W-1:0] flip_vec;
  logic [CODEWORD_W-1:0] cw_fix;
  logic [DATA_W-1:0]     data_next;
  logic                  accept;

  // busy covers reset and the cycle right after it
  assign busy   = rst | rst_q;
  assign accept = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      check_bits    <= RESET_CHECK_BITS;
      odd_parity    <= 1'b0;
      double_detect <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHECK_BITS:    check_bits    <= cfg_data;
        REG_ODD_PARITY:    odd_parity    <= cfg_data[0];
        REG_DOUBLE_DETECT: double_detect <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      rst_q    <= 1'b1;
      in_valid <= 1'b0;
    end else begin
      rst_q    <= 1'b0;
      in_valid <= accept;
    end
    if (accept) begin
      in_cw <= codeword;
    end
  end

  // effective check bit count and codeword length
  always_comb begin
    if (check_bits < MIN_CHECK_BITS) begin
      r_eff = MIN_CHECK_BITS;
    end else if (check_bits > MaxR) begin
      r_eff = MaxR;
    end else begin
      r_eff = check_bits;
    end
    n        = SYN_W'((7'd1 << r_eff) - 7'd1);
    len_mask = ~({CODEWORD_W{1'b1}} << n);
    cw_m     = in_cw & len_mask;
  end

  // syndrome and overall parity
  always_comb begin
    for (int p = 0; p < SYN_W; p++) begin
      syn[p] = (3'(p) < r_eff) ? ^(cw_m & syn_mask(p)) : 1'b0;
    end
    if (odd_parity) begin
      syn = syn ^ n;
    end
    overall = odd_parity ^ (^cw_m) ^ in_cw[n];
  end

  // sec / secded decision
  always_comb begin
    status_next   = STATUS_OK;
    flipped       = '0;
    mismatch_next = 1'b0;
    if (double_detect) begin
      mismatch_next = overall;
      if (overall) begin
        status_next = STATUS_CORRECTED;
        flipped     = syn;
      end else if (syn != '0) begin
        status_next = STATUS_DOUBLE;
      end
    end else if (syn != '0) begin
      status_next = STATUS_CORRECTED;
      flipped     = syn;
    end
  end

  // bit correction and packing of the non power of two positions
  always_comb begin
    int dpos;
    dpos      = 0;
    flip_vec  = (flipped != '0) ? ({{(CODEWORD_W-1){1'b0}}, 1'b1} << (flipped - 6'd1)) : '0;
    cw_fix    = cw_m ^ flip_vec;
    data_next = '0;
    for (int i = 0; i < CODEWORD_W - 1; i++) begin
      if (((i + 1) & i) != 0) begin
        data_next[SYN_W'(dpos)] = cw_fix[i];
        dpos = dpos + 1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      data_word        <= data_next;
      status           <= status_next;
      syndrome         <= flipped;
      overall_mismatch <= mismatch_next;
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted transaction did not complete after two cycles");

  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_OK) |-> (syndrome == '0 && !overall_mismatch))
    else $error("clean status with nonzero syndrome or mismatch");

  a_double_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_DOUBLE) |-> (syndrome == '0 && !overall_mismatch))
    else $error("double error reported with a flipped bit");

  a_mismatch_fix: assert property (@(posedge clk) disable iff (rst)
    (done && overall_mismatch) |-> status == STATUS_CORRECTED)
    else $error("overall mismatch without correction status");

  a_sec_no_mismatch: assert property (@(posedge clk) disable iff (rst)
    (done && !double_detect) |-> (!overall_mismatch && status != STATUS_DOUBLE))
    else $error("secded result in sec mode");
`endif

endmodule

`default_nettype wire
